// ===== hdl/lcgr_pkg.sv =====
`default_nettype none

package lcgr_pkg;

  // Generator constants
  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_ADD = 32'd12345;

  // Raw value width and remainder iterations (one quotient bit per cycle)
  localparam int RAW_W     = 31;
  localparam int DIV_STEPS = RAW_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Item kinds
  typedef enum logic [1:0] {
    KIND_SEED  = 2'd0,
    KIND_RAW   = 2'd1,
    KIND_RANGE = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic seed;   // add seed_value to generator state
    logic load;   // latch range operands for a draw
    logic mul;    // capture state * multiplier
    logic add;    // finish one generator step and take its slice
    logic first;  // this step is the first of the draw
    logic div;    // one remainder iteration
    logic fin;    // load output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic use_mod;  // range draw with nonzero span
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/lcgr_dpath.sv =====
`default_nettype none

module lcgr_dpath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lcgr_pkg::cmd_t      cmd,
  input  wire logic [1:0]          kind,
  input  wire logic [31:0]         seed_value,
  input  wire logic signed [31:0]  range_low,
  input  wire logic signed [31:0]  range_high,
  output lcgr_pkg::sts_t           sts,
  output logic signed [31:0]       random_value,
  output logic                     span_zero
);

  logic [31:0]                lcg_state;
  logic [31:0]                prod;
  logic [31:0]                stepped;
  logic [lcgr_pkg::RAW_W-1:0] raw;
  logic [31:0]                rem;
  logic [31:0]                low;
  logic [31:0]                span;
  logic                       use_mod;
  logic                       zero_flag;
  logic [31:0]                span_in;
  logic                       is_range;
  logic [32:0]                trial;
  logic [32:0]                trial_sub;
  logic [31:0]                addend;

  // Span of the incoming range, wrapped mod 2^32
  assign span_in  = $unsigned(range_high) - $unsigned(range_low) + 32'd1;
  assign is_range = (kind == lcgr_pkg::KIND_RANGE);

  // Finish one generator step
  assign stepped = prod + lcgr_pkg::LCG_ADD;

  // Restoring remainder step over the raw value, MSB first
  assign trial     = {rem, raw[lcgr_pkg::RAW_W-1]};
  assign trial_sub = trial - {1'b0, span};

  assign addend = use_mod ? rem : {{(32-lcgr_pkg::RAW_W){1'b0}}, raw};

  // Generator state: seed add or step
  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_state <= '0;
    end else if (cmd.seed) begin
      lcg_state <= lcg_state + seed_value;
    end else if (cmd.add) begin
      lcg_state <= stepped;
    end
  end

  // Multiply stage
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= lcg_state * lcgr_pkg::LCG_MUL;
    end
  end

  // Draw operands
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      low       <= is_range ? $unsigned(range_low) : 32'd0;
      span      <= span_in;
      use_mod   <= is_range && (span_in != 32'd0);
      zero_flag <= is_range && (span_in == 32'd0);
    end
  end

  // Raw value assembly, then reuse as the dividend shifter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem <= '0;
    end else if (cmd.div) begin
      rem <= (trial >= {1'b0, span}) ? trial_sub[31:0] : trial[31:0];
    end
    if (cmd.add) begin
      if (cmd.first) begin
        raw <= {{(lcgr_pkg::RAW_W-11){1'b0}}, stepped[26:16]};
      end else begin
        raw <= {raw[lcgr_pkg::RAW_W-11:0], stepped[25:16]};
      end
    end else if (cmd.div) begin
      raw <= {raw[lcgr_pkg::RAW_W-2:0], 1'b0};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      random_value <= $signed(low + addend);
      span_zero    <= zero_flag;
    end
  end

  assign sts.use_mod = use_mod;

endmodule

`default_nettype wire

// ===== hdl/lcgr_ctrl.sv =====
`default_nettype none

module lcgr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [1:0]     kind,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire lcgr_pkg::sts_t sts,
  output lcgr_pkg::cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_ADD  = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t                       state, state_next;
  logic [1:0]                   step, step_next;
  logic [lcgr_pkg::DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic                         out_valid_next;
  logic                         in_accept;
  logic                         is_draw;
  logic                         out_free;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign is_draw   = (kind == lcgr_pkg::KIND_RAW) || (kind == lcgr_pkg::KIND_RANGE);
  assign out_free  = !out_valid || !out_stall;

  // Sequence seed beats and draws
  always_comb begin
    state_next     = state;
    step_next      = step;
    div_cnt_next   = div_cnt;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          cmd.seed = (kind == lcgr_pkg::KIND_SEED);
          if (is_draw) begin
            cmd.load   = 1'b1;
            step_next  = 2'd0;
            state_next = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        cmd.first = (step == 2'd0);
        if (step == 2'd2) begin
          div_cnt_next = '0;
          state_next   = sts.use_mod ? S_DIV : S_FIN;
        end else begin
          step_next  = step + 2'd1;
          state_next = S_MUL;
        end
      end
      S_DIV: begin
        cmd.div      = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == lcgr_pkg::DIV_CNT_W'(lcgr_pkg::DIV_STEPS - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        // Hold until the output register is free
        if (out_free) begin
          cmd.fin        = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      div_cnt   <= div_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // A draw beat starts the multiply stage
  a_draw_start: assert property (@(posedge clk) disable iff (rst)
    (in_accept && is_draw) |=> (state == S_MUL))
    else $error("draw beat did not start generator");

  // The last remainder iteration leads to the output stage
  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_cnt == lcgr_pkg::DIV_CNT_W'(lcgr_pkg::DIV_STEPS - 1))
      |=> (state == S_FIN))
    else $error("remainder did not finish after last iteration");

  // A blocked output register holds the finished draw
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_valid && out_stall) |=> (state == S_FIN && out_valid))
    else $error("result loaded over a waiting beat");

  // Each multiply is followed by its add
  a_mul_add: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |=> (state == S_ADD))
    else $error("multiply not followed by add");

endmodule

`default_nettype wire

// ===== hdl/lcg_random_range_generator.sv =====
`default_nettype none

// Sequence: a raw draw, or a range draw whose span wraps to zero, runs 3 multiply/add
//   steps, then loads the output; a nonzero-span range draw runs the remainder iterations first.
// Flow: one draw at a time; the next beat is taken the cycle after the result loads,
//   and the result may wait on a stalled output. A seed beat does not leave the idle state.
// Reset: synchronous, active high; generator state clears to zero, no beat valid.
module lcg_random_range_generator (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         kind,
  input  wire logic [31:0]        seed_value,
  input  wire logic signed [31:0] range_low,
  input  wire logic signed [31:0] range_high,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      random_value,
  output logic                    span_zero
);

  lcgr_pkg::cmd_t cmd;
  lcgr_pkg::sts_t sts;

  // Sequencer
  lcgr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Generator, remainder unit and output register
  lcgr_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .kind         (kind),
    .seed_value   (seed_value),
    .range_low    (range_low),
    .range_high   (range_high),
    .sts          (sts),
    .random_value (random_value),
    .span_zero    (span_zero)
  );

endmodule

`default_nettype wire

// ===== test/lcg_random_range_generator_tb.sv =====
`default_nettype none

module lcg_random_range_generator_tb;

  // Generator step constants and run limits
  localparam logic [31:0] STEP_MUL   = 32'd1103515245;
  localparam logic [31:0] STEP_ADD   = 32'd12345;
  localparam int          HOLD_LEN   = 400;
  localparam int          IDLE_LIMIT = 4000;
  localparam int          DRAIN_WAIT = 60;

  typedef struct {
    logic [31:0] value;
    logic        zero;
  } draw_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          kind = lcgr_pkg::KIND_SEED;
  logic [31:0]         seed_value = '0;
  logic signed [31:0]  range_low = '0;
  logic signed [31:0]  range_high = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic signed [31:0]  random_value;
  logic                span_zero;

  logic [31:0]   gen_state = '0;
  draw_result_t  expected_draws[$];
  int            mismatch_count = 0;
  int            src_idle_pct = 0;
  int            sink_idle_pct = 0;
  bit            hold_request = 1'b0;
  int            hold_left = 0;
  int            quiet_cycles = 0;

  lcg_random_range_generator u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .seed_value   (seed_value),
    .range_low    (range_low),
    .range_high   (range_high),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .random_value (random_value),
    .span_zero    (span_zero)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Advance the generator once and return the state bits above bit 15
  function automatic logic [15:0] gen_step();
    gen_state = gen_state * STEP_MUL + STEP_ADD;
    return gen_state[31:16];
  endfunction

  // Build the 31-bit draw from an 11-bit slice and two 10-bit slices
  function automatic logic [31:0] gen_draw();
    logic [31:0] v;
    logic [15:0] s;
    v        = '0;
    s        = gen_step();
    v[30:20] = s[10:0];
    s        = gen_step();
    v[19:10] = s[9:0];
    s        = gen_step();
    v[9:0]   = s[9:0];
    return v;
  endfunction

  // Apply one accepted beat to the generator and queue the draw it produces
  function automatic void predict_draw(lcgr_pkg::kind_t k, logic [31:0] sd,
                                       logic [31:0] lo, logic [31:0] hi);
    draw_result_t r;
    logic [31:0]  raw;
    logic [31:0]  span;
    case (k)
      lcgr_pkg::KIND_SEED: begin
        gen_state = gen_state + sd;
      end
      lcgr_pkg::KIND_RAW: begin
        r.value = gen_draw();
        r.zero  = 1'b0;
        expected_draws.push_back(r);
      end
      lcgr_pkg::KIND_RANGE: begin
        raw  = gen_draw();
        span = hi - lo + 32'd1;
        if (span == 32'd0) begin
          r.value = lo + raw;
          r.zero  = 1'b1;
        end else begin
          r.value = lo + (raw % span);
          r.zero  = 1'b0;
        end
        expected_draws.push_back(r);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Offer one beat, hold it until accepted, then predict
  task automatic send_beat(input lcgr_pkg::kind_t k, input logic [31:0] sd,
                           input logic [31:0] lo, input logic [31:0] hi);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    seed_value <= sd;
    range_low  <= lo;
    range_high <= hi;
    do @(posedge clk); while (in_stall);
    predict_draw(k, sd, lo, hi);
  endtask

  task automatic set_idle(input int src_pct, input int sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
  endtask

  // Seeds at the extremes, raw draws, and an unused kind that must be dropped
  task automatic test_seed_and_raw();
    send_beat(lcgr_pkg::KIND_RAW, 32'h0, 32'h0, 32'h0);
    send_beat(lcgr_pkg::KIND_SEED, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_beat(lcgr_pkg::KIND_SEED, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(lcgr_pkg::KIND_RAW, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(lcgr_pkg::KIND_SEED, 32'h1, 32'h0, 32'h0);
    send_beat(lcgr_pkg::KIND_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(lcgr_pkg::KIND_RAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_beat(lcgr_pkg::KIND_SEED, 32'h0, 32'h0, 32'h0);
    send_beat(lcgr_pkg::KIND_RAW, 32'h0, 32'h0, 32'h0);
  endtask

  // Single-value ranges, inverted ranges and spans that wrap to zero
  task automatic test_range_corners();
    send_beat(lcgr_pkg::KIND_RANGE, 32'h0, 32'h0, 32'h0);
    send_beat(lcgr_pkg::KIND_RANGE, 32'h0, 32'h8000_0000, 32'h8000_0000);
    send_beat(lcgr_pkg::KIND_RANGE, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_beat(lcgr_pkg::KIND_RANGE, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(lcgr_pkg::KIND_RANGE, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_beat(lcgr_pkg::KIND_RANGE, 32'h0, 32'h1, 32'h0);
    send_beat(lcgr_pkg::KIND_RANGE, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_beat(lcgr_pkg::KIND_RANGE, 32'h0, 32'd5, 32'd3);
    send_beat(lcgr_pkg::KIND_RANGE, 32'h0, -32'sd10, 32'sd10);
    send_beat(lcgr_pkg::KIND_RANGE, 32'h0, 32'h0, 32'h7FFF_FFFF);
    send_beat(lcgr_pkg::KIND_RANGE, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
  endtask

  // Mix of seeds and draws with ranges of every shape
  task automatic test_random_mix(input int beats);
    int              sent;
    int              pick;
    lcgr_pkg::kind_t k;
    logic [31:0]     sd;
    logic [31:0]     lo;
    logic [31:0]     hi;
    sent = 0;
    while (sent < beats) begin
      pick = $urandom_range(99);
      sd   = $urandom;
      lo   = $urandom;
      hi   = $urandom;
      if (pick < 15)      k = lcgr_pkg::KIND_SEED;
      else if (pick < 45) k = lcgr_pkg::KIND_RAW;
      else if (pick < 93) k = lcgr_pkg::KIND_RANGE;
      else                k = lcgr_pkg::KIND_NONE;
      case ($urandom_range(5))
        0: hi = lo + $urandom_range(15);
        1: hi = lo + $urandom_range(65535);
        2: hi = lo;
        3: hi = lo - 32'd1;
        4: begin
          // straddle the signed top so the range may come out inverted
          lo = 32'h7FFF_FFFF - $urandom_range(7);
          hi = lo + $urandom_range(15);
        end
        default: ;
      endcase
      send_beat(k, sd, lo, hi);
      sent++;
    end
  endtask

  // Hold the output off for a long stretch while beats keep coming
  task automatic test_output_backpressure();
    int          i;
    int          saved_src;
    logic [31:0] lo;
    saved_src    = src_idle_pct;
    src_idle_pct = 0;
    hold_request = 1'b1;
    for (i = 0; i < 40; i++) begin
      lo = $urandom;
      if (i % 2 == 0) send_beat(lcgr_pkg::KIND_RAW, $urandom, lo, $urandom);
      else send_beat(lcgr_pkg::KIND_RANGE, $urandom, lo, lo + $urandom_range(1000));
    end
    src_idle_pct = saved_src;
  endtask

  // Drive output stall: a requested hold-off first, else random
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_LEN;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  // Check each output beat against the oldest expected draw
  always @(posedge clk) begin
    draw_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_draws.size() == 0) begin
        report_mismatch("unexpected beat", random_value, 32'h0);
      end else begin
        want = expected_draws.pop_front();
        if (random_value !== want.value)
          report_mismatch("random_value", random_value, want.value);
        if (span_zero !== want.zero)
          report_mismatch("span_zero", {31'h0, span_zero}, {31'h0, want.zero});
      end
    end
  end

  // End the run when neither side moves a beat for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idle(18, 50);
    test_seed_and_raw();
    test_range_corners();
    test_random_mix(400);

    set_idle(50, 18);
    test_random_mix(400);
    test_output_backpressure();

    set_idle(0, 0);
    test_random_mix(400);

    // Drain outstanding draws, then watch for stray beats
    in_valid <= 1'b0;
    while (expected_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
